// File: rtl/ring_buffer_fifo_macros.svh
// Assertion macros for the ring buffer FIFO checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef RING_BUFFER_FIFO_MACROS_SVH
`define RING_BUFFER_FIFO_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RBF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RBF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rbf_pkg.sv
// Shared types and constants for the ring buffer FIFO.
// Used by the interfaces, the controller, the memory and the top level.
package rbf_pkg;

  localparam int PTR_BITS  = 7;   // free-running pointers, modulo 128
  localparam int ADDR_BITS = 6;   // widest store address (64 entries)
  localparam int DATA_BITS = 32;  // word width on the ports

  typedef enum logic [2:0] {
    CMD_ENQ  = 3'd0,
    CMD_DEQ  = 3'd1,
    CMD_PEEK = 3'd2,
    CMD_SKIP = 3'd3,
    CMD_RST  = 3'd4
  } cmd_t;

  // Store access issued by the controller.
  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    logic [DATA_BITS-1:0] wdata;
    logic                 re;
    logic [ADDR_BITS-1:0] raddr;
  } mem_req_t;

  // Result word held in the output register, less the element itself.
  typedef struct packed {
    logic                valid;
    logic                data_valid;
    logic [PTR_BITS-1:0] granted;
    logic [PTR_BITS-1:0] fill_level;
    logic                last;
  } res_t;

endpackage

// File: rtl/rbf_if.sv
// Valid/ready channel interfaces for the ring buffer FIFO.
// Depends on rbf_pkg for field widths.
interface rbf_in_if import rbf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [2:0]           command;
  logic [DATA_BITS-1:0] write_data;
  logic [PTR_BITS-1:0]  request_count;

  modport source (output valid, command, write_data, request_count, input ready);
  modport sink   (input valid, command, write_data, request_count, output ready);
endinterface

interface rbf_out_if import rbf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DATA_BITS-1:0] read_data;
  logic                 data_valid;
  logic [PTR_BITS-1:0]  granted;
  logic [PTR_BITS-1:0]  fill_level;
  logic                 last;

  modport source (output valid, read_data, data_valid, granted, fill_level, last,
                  input ready);
  modport sink   (input valid, read_data, data_valid, granted, fill_level, last,
                  output ready);
endinterface

// File: rtl/rbf_mem.sv
// Element store: one write port, one read port, registered read data.
// Depends on rbf_pkg for the access request type.
module rbf_mem import rbf_pkg::*; #(
  parameter int AW = 6,
  parameter int SB = 32
) (
  input  logic          clk,
  input  mem_req_t      req,
  output logic [SB-1:0] rd_data
);

  localparam int ENTRIES = 1 << AW;

  logic [SB-1:0] store_mem [ENTRIES];
  logic [SB-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      store_mem[req.waddr[AW-1:0]] <= req.wdata[SB-1:0];
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= store_mem[req.raddr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/rbf_ctrl.sv
// Pointer and read sequencer for the ring buffer FIFO.
// Depends on rbf_pkg and the channel interfaces in rbf_if.sv.
module rbf_ctrl import rbf_pkg::*; #(
  parameter int CAP = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  rbf_in_if.sink      in_ch,
  input  logic        out_ready,
  output res_t        res,
  output mem_req_t    req
);

  localparam logic [PTR_BITS-1:0] CAP_LVL = PTR_BITS'(CAP);

  logic [PTR_BITS-1:0] wp_r, wp_nxt;
  logic [PTR_BITS-1:0] rp_r, rp_nxt;
  logic [PTR_BITS-1:0] rem_r, rem_nxt;      // reads still to issue
  logic [PTR_BITS-1:0] raddr_r, raddr_nxt;  // next read position
  res_t                res_r, res_nxt;

  logic [PTR_BITS-1:0] lvl;
  logic [PTR_BITS-1:0] n_grant;
  logic                out_free;
  logic                accept;
  cmd_t                cmd;

  assign cmd      = cmd_t'(in_ch.command);
  assign lvl      = wp_r - rp_r;
  assign n_grant  = (in_ch.request_count < lvl) ? in_ch.request_count : lvl;
  assign out_free = !res_r.valid || out_ready;
  assign in_ch.ready = (rem_r == '0) && out_free;
  assign accept   = in_ch.valid && in_ch.ready;

  always_comb begin
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    rem_nxt   = rem_r;
    raddr_nxt = raddr_r;
    res_nxt   = res_r;
    req       = '0;

    if (res_r.valid && out_ready) begin
      res_nxt.valid = 1'b0;
    end

    if (rem_r != '0) begin
      // Stream the next element when the output slot frees up.
      if (out_free) begin
        req.re             = 1'b1;
        req.raddr          = raddr_r[ADDR_BITS-1:0];
        rem_nxt            = rem_r - 1'b1;
        raddr_nxt          = raddr_r + 1'b1;
        res_nxt.valid      = 1'b1;
        res_nxt.data_valid = 1'b1;
        res_nxt.last       = (rem_r == PTR_BITS'(1));
      end
    end else if (accept) begin
      res_nxt.valid      = 1'b1;
      res_nxt.data_valid = 1'b0;
      res_nxt.granted    = '0;
      res_nxt.fill_level = lvl;
      res_nxt.last       = 1'b1;
      case (cmd)
        CMD_ENQ: begin
          if (lvl < CAP_LVL) begin
            req.we             = 1'b1;
            req.waddr          = wp_r[ADDR_BITS-1:0];
            req.wdata          = in_ch.write_data;
            wp_nxt             = wp_r + 1'b1;
            res_nxt.granted    = PTR_BITS'(1);
            res_nxt.fill_level = lvl + 1'b1;
          end
        end
        CMD_DEQ, CMD_PEEK: begin
          if (n_grant != '0) begin
            req.re             = 1'b1;
            req.raddr          = rp_r[ADDR_BITS-1:0];
            rem_nxt            = n_grant - 1'b1;
            raddr_nxt          = rp_r + 1'b1;
            res_nxt.data_valid = 1'b1;
            res_nxt.granted    = n_grant;
            res_nxt.last       = (n_grant == PTR_BITS'(1));
            if (cmd == CMD_DEQ) begin
              rp_nxt             = rp_r + n_grant;
              res_nxt.fill_level = lvl - n_grant;
            end
          end
        end
        CMD_SKIP: begin
          rp_nxt             = rp_r + n_grant;
          res_nxt.granted    = n_grant;
          res_nxt.fill_level = lvl - n_grant;
        end
        CMD_RST: begin
          wp_nxt             = '0;
          rp_nxt             = '0;
          res_nxt.fill_level = '0;
        end
        default: begin
          // Unknown command: report the level, change nothing.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      rem_r   <= '0;
      raddr_r <= '0;
      res_r   <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      rem_r   <= rem_nxt;
      raddr_r <= raddr_nxt;
      res_r   <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// File: rtl/ring_buffer_fifo.sv
// Ring buffer FIFO top level: controller plus element store.
// Depends on rbf_pkg, rbf_if.sv, rbf_ctrl and rbf_mem.
//
// Usage:
//   in_ch carries one command word: enqueue, dequeue, peek, skip or reset,
//   with write_data and request_count. out_ch returns the result words.
//   Enqueue, skip, reset, unknown codes and dequeue/peek that grant nothing
//   give one word with data_valid low and last high. Dequeue and peek give
//   one word per granted element, last high on the final one.
//   The first result word is registered and is valid in the cycle after acceptance.
//   Throughput: single-result commands go at one per cycle while out_ch is
//   not stalled. A dequeue or peek of n elements streams one word per cycle
//   through the single read port of the store while out_ch is not stalled,
//   and the next command is taken once the final read has been issued.
//   Capacity is DEPTH rounded up to a power of two; fill_level is the
//   difference of two free-running 7-bit pointers.
//   Reset (rst_n low, synchronous) clears both pointers and the output
//   register; stored data is kept but no longer reachable.
//   When out_ch stalls, the pending word holds and no new command or read
//   is taken until it leaves.
module ring_buffer_fifo import rbf_pkg::*; #(
  parameter int DEPTH        = 64,
  parameter int ELEMENT_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  rbf_in_if.sink     in_ch,
  rbf_out_if.source  out_ch
);

  // Ring size is the next power of two at or above DEPTH.
  localparam int AW  = $clog2(DEPTH);
  localparam int CAP = 1 << AW;
  // Only the low word bits ever reach the ports.
  localparam int SB  = (ELEMENT_BITS < DATA_BITS) ? ELEMENT_BITS : DATA_BITS;

  res_t                 res;
  mem_req_t             req;
  logic [SB-1:0]        rd_data;
  logic [DATA_BITS-1:0] rd_data_ext;

  rbf_ctrl #(
    .CAP (CAP)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ready (out_ch.ready),
    .res       (res),
    .req       (req)
  );

  rbf_mem #(
    .AW (AW),
    .SB (SB)
  ) u_mem (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  // Zero-extend the stored element to the port width.
  always_comb begin
    rd_data_ext         = '0;
    rd_data_ext[SB-1:0] = rd_data;
  end

  // Drive zero data on words that carry no element.
  assign out_ch.valid      = res.valid;
  assign out_ch.read_data  = res.data_valid ? rd_data_ext : '0;
  assign out_ch.data_valid = res.data_valid;
  assign out_ch.granted    = res.granted;
  assign out_ch.fill_level = res.fill_level;
  assign out_ch.last       = res.last;

endmodule

// File: rtl/rbf_chk.sv
// Port-level checker for the ring buffer FIFO, bound to the top level.
// Depends on rbf_pkg and ring_buffer_fifo_macros.svh.
`include "ring_buffer_fifo_macros.svh"

module rbf_chk import rbf_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [DATA_BITS-1:0] out_read_data,
  input logic                 out_data_valid,
  input logic [PTR_BITS-1:0]  out_granted,
  input logic [PTR_BITS-1:0]  out_fill_level,
  input logic                 out_last
);

  `RBF_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                  out_valid && $stable(out_read_data) && $stable(out_last),
                  "stalled result word changed")
  `RBF_ASSERT_IMP(a_no_data_zero, out_valid && !out_data_valid, out_read_data == '0,
                  "read_data nonzero without an element")
  `RBF_ASSERT_IMP(a_fill_range, out_valid, out_fill_level <= PTR_BITS'(64),
                  "fill level beyond capacity")
  `RBF_ASSERT_IMP(a_data_granted, out_valid && out_data_valid, out_granted != '0,
                  "element returned with zero grant")
  `RBF_ASSERT_IMP(a_busy_stream, out_valid && !out_last, !in_ready,
                  "command taken while a read stream is open")

endmodule

bind ring_buffer_fifo rbf_chk u_rbf_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_read_data  (out_ch.read_data),
  .out_data_valid (out_ch.data_valid),
  .out_granted    (out_ch.granted),
  .out_fill_level (out_ch.fill_level),
  .out_last       (out_ch.last)
);
